[rtl/ksr_pkg.sv]
// Package for the keyed score table: command codes, queue item type and
// back-end state type. No dependencies.
package ksr_pkg;

    localparam int KEY_W   = 10;
    localparam int SCORE_W = 4;
    localparam int REP_W   = 8;
    localparam int RANK_W  = 8;
    localparam int TOT_W   = 32;
    localparam int PCT_W   = 8;
    localparam int PPM_W   = 4;
    localparam int IN_DW   = 32;
    localparam int OUT_DW  = 56;
    localparam int PCT_SCALE = 100;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_RANK  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [REP_W-1:0]   rep;
        logic [RANK_W-1:0]  rank;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CMP,
        S_Q_MUL,
        S_Q_CHK,
        S_Q_DIV,
        S_RK_I_RD,
        S_RK_I_CAP,
        S_RK_J_RD,
        S_RK_J_CMP,
        S_OUT
    } t_state;

endpackage

[rtl/keyed_score_table_with_rank.sv]
// Keyed score table with rank: front end, back end and points-per-match register.
// Depends on ksr_pkg, ksr_front, ksr_back.
// Each add or query searches the used entries in order; a query hit then works out the
// percentage, through the 8-step divider unless it saturates; a rank compares entry pairs.
// The back end takes the next item only once the last result is registered; the queue holds two more items.
// Synchronous active-low reset empties the table and queue and sets the register to 3.
module keyed_score_table_with_rank #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // key_id, score, repeat_req, rank, pad
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // valid_res, table_full, total_out,
                                       // percent, key_out, pad
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata    // points_per_match
);
    import ksr_pkg::*;

    logic [PPM_W-1:0] r_ppm;
    logic  w_q_valid, w_q_pop;
    t_item w_q_item;
    logic [$clog2(TABLE_ENTRIES+1)-1:0] w_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ppm <= PPM_W'(3);
        else if (i_cfg_we) r_ppm <= i_cfg_wdata;
    end

    ksr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .o_q_valid(w_q_valid), .o_q_item(w_q_item), .i_q_pop(w_q_pop));

    ksr_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ppm(r_ppm),
        .i_q_valid(w_q_valid), .i_q_item(w_q_item), .o_q_pop(w_q_pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .o_used(w_used));

    a_full_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("table full flagged on an accepted item");

    a_pct_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[41:34] != 8'd0) |-> m_axis_tdata[0])
        else $error("percent on a missing key");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= ($clog2(TABLE_ENTRIES+1))'(TABLE_ENTRIES))
        else $error("entry count overflow");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_used != $past(w_used)) |-> (w_used == $past(w_used) + 1'b1))
        else $error("entry count moved by more than one");
endmodule

[rtl/ksr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ksr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/ksr_front.sv]
// Front end: accepts input items, decodes the command and holds them in a
// two-entry queue for the back end. Depends on ksr_pkg.
module ksr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ksr_pkg::IN_DW-1:0]   s_axis_tdata,
    input  logic [1:0]                  s_axis_tuser,
    output logic                        o_q_valid,
    output ksr_pkg::t_item              o_q_item,
    input  logic                        i_q_pop
);
    import ksr_pkg::*;

    t_item      r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.op    = t_op'(s_axis_tuser);
        w_item.key   = s_axis_tdata[9:0];
        w_item.score = s_axis_tdata[13:10];
        w_item.rep   = s_axis_tdata[21:14];
        w_item.rank  = s_axis_tdata[29:22];
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign o_q_item      = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

[rtl/ksr_back.sv]
// Back end: sequencer over the key, total and count memories that carries
// out add, query (with a bit-serial divider) and rank. Depends on ksr_pkg,
// ksr_ram.
module ksr_back #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ksr_pkg::PPM_W-1:0]     i_ppm,
    input  logic                          i_q_valid,
    input  ksr_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ksr_pkg::OUT_DW-1:0]    m_axis_tdata,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] o_used
);
    import ksr_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int WC = (CW > RANK_W) ? CW : RANK_W;
    localparam int NUM_W = TOT_W + 7;
    localparam int DEN_W = TOT_W + PPM_W;
    localparam int CMP_W = DEN_W + 8;

    t_state r_state, n_state;
    t_item  r_item;
    logic [CW-1:0] r_used, r_i, r_j, r_pos;
    logic [TOT_W-1:0] r_tot, r_cnt, r_ti;
    logic [KEY_W-1:0] r_ki;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [2:0] r_k;
    logic [PCT_W-1:0] r_q;
    logic r_rv, r_rf;
    logic [TOT_W-1:0] r_rt;
    logic [PCT_W-1:0] r_rp;
    logic [KEY_W-1:0] r_rk;

    logic [IW-1:0]    w_raddr, w_waddr;
    logic             w_we;
    logic [KEY_W-1:0] rd_key;
    logic [TOT_W-1:0] rd_tot, rd_cnt, w_wtot, w_wcnt;
    logic [TOT_W:0]   w_sum_t, w_sum_c;
    logic [TOT_W-1:0] w_base_t, w_base_c;
    logic [11:0]      w_prod;
    logic             w_hit, w_miss, w_room, w_rank_ok, w_beats;
    logic [CMP_W-1:0] w_trial;

    ksr_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_item.key),
        .i_raddr(w_raddr), .o_rdata(rd_key));
    ksr_ram #(.WIDTH(TOT_W), .DEPTH(TABLE_ENTRIES)) u_tot (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wtot),
        .i_raddr(w_raddr), .o_rdata(rd_tot));
    ksr_ram #(.WIDTH(TOT_W), .DEPTH(TABLE_ENTRIES)) u_cnt (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wcnt),
        .i_raddr(w_raddr), .o_rdata(rd_cnt));

    assign o_used = r_used;
    assign w_hit  = (r_state == S_LK_CMP) && (rd_key == r_item.key);
    assign w_miss = (r_state == S_LK_RD) && (r_i == r_used);
    assign w_room = (r_used != CW'(TABLE_ENTRIES));
    assign w_rank_ok = WC'(i_q_item.rank) < WC'(r_used);
    assign w_beats = (rd_tot > r_ti) || ((r_j < r_i) && (rd_tot == r_ti));
    assign w_trial = CMP_W'(r_den) << r_k;

    // add datapath: a new entry starts from zero
    always_comb begin
        w_prod   = 12'(r_item.score) * 12'(r_item.rep);
        w_base_t = w_hit ? rd_tot : '0;
        w_base_c = w_hit ? rd_cnt : '0;
        w_sum_t  = {1'b0, w_base_t} + (TOT_W+1)'(w_prod);
        w_sum_c  = {1'b0, w_base_c} + (TOT_W+1)'(r_item.rep);
        w_wtot   = w_sum_t[TOT_W] ? '1 : w_sum_t[TOT_W-1:0];
        w_wcnt   = w_sum_c[TOT_W] ? '1 : w_sum_c[TOT_W-1:0];
        w_we     = (r_item.op == OP_ADD) && (w_hit || (w_miss && w_room));
        w_waddr  = w_hit ? r_i[IW-1:0] : r_used[IW-1:0];
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        w_raddr = r_i[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    case (i_q_item.op)
                        OP_ADD, OP_QUERY: n_state = S_LK_RD;
                        OP_RANK:          n_state = w_rank_ok ? S_RK_I_RD : S_OUT;
                        default:          n_state = S_OUT;
                    endcase
                end
            end
            S_LK_RD:    n_state = w_miss ? S_OUT : S_LK_CMP;
            S_LK_CMP: begin
                if (!w_hit) n_state = S_LK_RD;
                else if (r_item.op == OP_ADD) n_state = S_OUT;
                else n_state = S_Q_MUL;
            end
            S_Q_MUL:    n_state = S_Q_CHK;
            S_Q_CHK: begin
                if (r_den == '0 || {5'b0, r_num} >= {r_den, 8'b0}) n_state = S_OUT;
                else n_state = S_Q_DIV;
            end
            S_Q_DIV:    n_state = (r_k == 3'd0) ? S_OUT : S_Q_DIV;
            S_RK_I_RD:  n_state = S_RK_I_CAP;
            S_RK_I_CAP: n_state = S_RK_J_RD;
            S_RK_J_RD: begin
                w_raddr = r_j[IW-1:0];
                if (r_j == r_used)
                    n_state = (WC'(r_pos) == WC'(r_item.rank)) ? S_OUT : S_RK_I_RD;
                else n_state = S_RK_J_CMP;
            end
            S_RK_J_CMP: n_state = S_RK_J_RD;
            S_OUT:      n_state = (!m_axis_tvalid || m_axis_tready) ? S_IDLE : S_OUT;
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_used        <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we && !w_hit) r_used <= r_used + 1'b1;
            if (r_state == S_OUT && (!m_axis_tvalid || m_axis_tready))
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_q_item;
                r_i    <= '0;
                {r_rv, r_rf, r_rt, r_rp, r_rk} <= '0;
            end
            S_LK_RD: begin
                if (w_miss && r_item.op == OP_ADD) begin
                    r_rv <= w_room;
                    r_rf <= !w_room;
                end
            end
            S_LK_CMP: begin
                if (w_hit) begin
                    r_rv  <= 1'b1;
                    r_tot <= rd_tot;
                    r_cnt <= rd_cnt;
                    if (r_item.op == OP_QUERY) r_rt <= rd_tot;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_Q_MUL: begin
                r_num <= NUM_W'(r_tot) * NUM_W'(PCT_SCALE);
                r_den <= DEN_W'(r_cnt) * DEN_W'(i_ppm);
            end
            S_Q_CHK: begin
                r_k <= 3'd7;
                r_q <= '0;
                if (r_den != '0 && {5'b0, r_num} >= {r_den, 8'b0}) r_rp <= '1;
            end
            S_Q_DIV: begin
                if (CMP_W'(r_num) >= w_trial) begin
                    r_num <= NUM_W'(CMP_W'(r_num) - w_trial);
                    r_q   <= r_q | (PCT_W'(1) << r_k);
                    if (r_k == 3'd0) r_rp <= r_q | (PCT_W'(1) << r_k);
                end else if (r_k == 3'd0) begin
                    r_rp <= r_q;
                end
                r_k <= r_k - 3'd1;
            end
            S_RK_I_CAP: begin
                r_ti  <= rd_tot;
                r_ki  <= rd_key;
                r_j   <= '0;
                r_pos <= '0;
            end
            S_RK_J_RD: begin
                if (r_j == r_used) begin
                    if (WC'(r_pos) == WC'(r_item.rank)) begin
                        r_rv <= 1'b1;
                        r_rk <= r_ki;
                    end
                    r_i <= r_i + 1'b1;
                end
            end
            S_RK_J_CMP: begin
                if (w_beats) r_pos <= r_pos + 1'b1;
                r_j <= r_j + 1'b1;
            end
            S_OUT: begin
                if (!m_axis_tvalid || m_axis_tready)
                    m_axis_tdata <= {4'b0, r_rk, r_rp, r_rt, r_rf, r_rv};
            end
            default: ;
        endcase
    end
endmodule
